[hw/rtl/atq_pkg.sv]
// Package for the autotile quarter source lookup.
// Holds the command record type, piece codes and the sheet-cell tables.
package atq_pkg;

  typedef struct packed {
    logic [8:0] src_x;
    logic [7:0] src_y;
    logic [3:0] dst_x;
    logic [3:0] dst_y;
    logic       whole_tile;
  } cmd_t;

  // Coast piece rows; PC_NONE means the quarter is skipped.
  localparam logic [3:0] PC_A    = 4'd0;
  localparam logic [3:0] PC_B    = 4'd1;
  localparam logic [3:0] PC_C    = 4'd2;
  localparam logic [3:0] PC_D    = 4'd3;
  localparam logic [3:0] PC_NONE = 4'd12;

  // Terrain pieces, row*3+column inside the 3x4 piece block.
  localparam logic [3:0] PT_C  = 4'd2;
  localparam logic [3:0] PT_D7 = 4'd3;
  localparam logic [3:0] PT_D8 = 4'd4;
  localparam logic [3:0] PT_D9 = 4'd5;
  localparam logic [3:0] PT_D4 = 4'd6;
  localparam logic [3:0] PT_D5 = 4'd7;
  localparam logic [3:0] PT_D6 = 4'd8;
  localparam logic [3:0] PT_D1 = 4'd9;
  localparam logic [3:0] PT_D2 = 4'd10;
  localparam logic [3:0] PT_D3 = 4'd11;

  function automatic logic [4:0] grp_cx(input logic [3:0] g);
    case (g)
      4'd0, 4'd2: grp_cx = 5'd0;
      4'd1, 4'd3: grp_cx = 5'd3;
      4'd4, 4'd6, 4'd8, 4'd10: grp_cx = 5'd6;
      default: grp_cx = 5'd9;
    endcase
  endfunction

  function automatic logic [3:0] grp_cy(input logic [3:0] g);
    case (g)
      4'd4, 4'd5: grp_cy = 4'd0;
      4'd6, 4'd7: grp_cy = 4'd4;
      4'd0, 4'd1, 4'd8, 4'd9: grp_cy = 4'd8;
      default: grp_cy = 4'd12;
    endcase
  endfunction

  // Piece code to column (code mod 3) and row (code div 3).
  function automatic logic [1:0] pc_col(input logic [3:0] p);
    pc_col = 2'(p - 4'd3 * (p >= 4'd3) - 4'd3 * (p >= 4'd6) - 4'd3 * (p >= 4'd9));
  endfunction

  function automatic logic [1:0] pc_row(input logic [3:0] p);
    pc_row = 2'(32'(p >= 4'd3) + 32'(p >= 4'd6) + 32'(p >= 4'd9));
  endfunction

endpackage

[hw/rtl/atq_decode.sv]
// Decoder: turns one registered tile beat into up to eight blit commands.
// Depends on atq_pkg for the command type, piece codes and group tables.
module atq_decode (
  input  logic [15:0]        tile_id,
  input  logic               upper_layer,
  input  logic [15:0]        frame,
  output atq_pkg::cmd_t [7:0] cmds,
  output logic [7:0]         cmd_en
);
  import atq_pkg::*;

  logic [15:0] id_m800, id_m50, idx50, rel, px, py, blk;
  logic [3:0]  bits, g;
  logic [1:0]  f3;
  logic [4:0]  cx, base_cx;
  logic [3:0]  cy;
  logic [5:0]  c;
  logic [3:0]  q [4];
  logic [3:0]  t_q [4];
  logic        cls_up, cls_coast, cls_anim, cls_terr, cls_plain;

  // Remainders and quotients by constants, done with a subtract chain and reciprocal multiplies.
  always_comb begin
    id_m800 = tile_id;
    for (int k = 0; k < 4; k++) if (id_m800 >= 16'd800) id_m800 = id_m800 - 16'd800;
    bits = 4'((32'(id_m800) * 1311) >> 16);
    idx50 = 16'((32'(tile_id) * 1311) >> 16);
    if (16'(idx50 * 16'd50) > tile_id) idx50 = idx50 - 16'd1;
    id_m50 = tile_id - 16'(idx50 * 16'd50);
    c = id_m50[5:0];
    f3 = 2'(frame - 16'(16'((32'(frame) * 43691) >> 17) * 16'd3));
  end

  // Plain cell folding: 6-wide index into 6x8 blocks.
  always_comb begin
    if (upper_layer) rel = tile_id - 16'd10000 + 16'd336;
    else rel = tile_id - 16'd5000 + 16'd192;
    py = 16'((32'(rel) * 43691) >> 18);
    px = rel - 16'(py * 16'd6);
    blk = py >> 3;
    if (blk > 16'd9) blk = 16'd9;
  end

  // Coast pieces per corner code.
  always_comb begin
    for (int i = 0; i < 4; i++) q[i] = PC_NONE;
    if (c < 6'h10) begin
      if (c[0]) q[0] = PC_D;
      if (c[1]) q[1] = PC_D;
      if (c[2]) q[3] = PC_D;
      if (c[3]) q[2] = PC_D;
    end else if (c < 6'h14) begin
      q[0] = PC_B; q[2] = PC_B;
      if (c[0]) q[1] = PC_D;
      if (c[1]) q[3] = PC_D;
    end else if (c < 6'h18) begin
      q[0] = PC_C; q[1] = PC_C;
      if (c[0]) q[3] = PC_D;
      if (c[1]) q[2] = PC_D;
    end else if (c < 6'h1C) begin
      q[1] = PC_B; q[3] = PC_B;
      if (c[0]) q[2] = PC_D;
      if (c[1]) q[0] = PC_D;
    end else if (c < 6'h20) begin
      q[2] = PC_C; q[3] = PC_C;
      if (c[0]) q[0] = PC_D;
      if (c[1]) q[1] = PC_D;
    end else if (c == 6'h20) begin
      for (int i = 0; i < 4; i++) q[i] = PC_B;
    end else if (c == 6'h21) begin
      for (int i = 0; i < 4; i++) q[i] = PC_C;
    end else if (c <= 6'h23) begin
      q[0] = PC_A; q[2] = PC_B; q[1] = PC_C;
      if (c[0]) q[3] = PC_D;
    end else if (c <= 6'h25) begin
      q[1] = PC_A; q[3] = PC_B; q[0] = PC_C;
      if (c[0]) q[2] = PC_D;
    end else if (c <= 6'h27) begin
      q[3] = PC_A; q[1] = PC_B; q[2] = PC_C;
      if (c[0]) q[0] = PC_D;
    end else if (c <= 6'h29) begin
      q[2] = PC_A; q[0] = PC_B; q[3] = PC_C;
      if (c[0]) q[1] = PC_D;
    end else if (c == 6'h2A) begin
      q[0] = PC_A; q[1] = PC_A; q[2] = PC_B; q[3] = PC_B;
    end else if (c == 6'h2B) begin
      q[0] = PC_A; q[2] = PC_A; q[1] = PC_C; q[3] = PC_C;
    end else if (c == 6'h2C) begin
      q[2] = PC_A; q[3] = PC_A; q[0] = PC_B; q[1] = PC_B;
    end else if (c == 6'h2D) begin
      q[1] = PC_A; q[3] = PC_A; q[0] = PC_C; q[2] = PC_C;
    end else begin
      for (int i = 0; i < 4; i++) q[i] = PC_A;
    end
  end

  // Terrain pieces per corner code.
  always_comb begin
    for (int i = 0; i < 4; i++) t_q[i] = PT_D5;
    if (c < 6'h10) begin
      if (c[0]) t_q[0] = PT_C;
      if (c[1]) t_q[1] = PT_C;
      if (c[2]) t_q[3] = PT_C;
      if (c[3]) t_q[2] = PT_C;
    end else if (c < 6'h14) begin
      t_q[0] = PT_D4; t_q[2] = PT_D4;
      if (c[0]) t_q[1] = PT_C;
      if (c[1]) t_q[3] = PT_C;
    end else if (c < 6'h18) begin
      t_q[0] = PT_D8; t_q[1] = PT_D8;
      if (c[0]) t_q[3] = PT_C;
      if (c[1]) t_q[2] = PT_C;
    end else if (c < 6'h1C) begin
      t_q[1] = PT_D6; t_q[3] = PT_D6;
      if (c[0]) t_q[2] = PT_C;
      if (c[1]) t_q[0] = PT_C;
    end else if (c < 6'h20) begin
      t_q[2] = PT_D2; t_q[3] = PT_D2;
      if (c[0]) t_q[0] = PT_C;
      if (c[1]) t_q[1] = PT_C;
    end else if (c == 6'h20) begin
      t_q[0] = PT_D4; t_q[2] = PT_D4; t_q[1] = PT_D6; t_q[3] = PT_D6;
    end else if (c == 6'h21) begin
      t_q[0] = PT_D8; t_q[1] = PT_D8; t_q[2] = PT_D2; t_q[3] = PT_D2;
    end else if (c <= 6'h23) begin
      for (int i = 0; i < 4; i++) t_q[i] = PT_D7;
      if (c[0]) t_q[3] = PT_C;
    end else if (c <= 6'h25) begin
      for (int i = 0; i < 4; i++) t_q[i] = PT_D9;
      if (c[0]) t_q[2] = PT_C;
    end else if (c <= 6'h27) begin
      for (int i = 0; i < 4; i++) t_q[i] = PT_D3;
      if (c[0]) t_q[0] = PT_C;
    end else if (c <= 6'h29) begin
      for (int i = 0; i < 4; i++) t_q[i] = PT_D1;
      if (c[0]) t_q[1] = PT_C;
    end else if (c == 6'h2A) begin
      t_q[0] = PT_D7; t_q[2] = PT_D7; t_q[1] = PT_D9; t_q[3] = PT_D9;
    end else if (c == 6'h2B) begin
      t_q[0] = PT_D7; t_q[1] = PT_D7; t_q[2] = PT_D1; t_q[3] = PT_D1;
    end else if (c == 6'h2C) begin
      t_q[0] = PT_D1; t_q[2] = PT_D1; t_q[1] = PT_D3; t_q[3] = PT_D3;
    end else if (c == 6'h2D) begin
      t_q[0] = PT_D9; t_q[1] = PT_D9; t_q[2] = PT_D3; t_q[3] = PT_D3;
    end else begin
      t_q[0] = PT_D7; t_q[1] = PT_D9; t_q[2] = PT_D1; t_q[3] = PT_D3;
    end
  end

  // Class of the id and the command list.
  always_comb begin
    logic [3:0] ox, oy;
    logic [1:0] t;
    logic [3:0] gg;
    t = 2'd0;
    cls_up    = upper_layer && tile_id >= 16'd10000 && tile_id < 16'd10144;
    cls_coast = !upper_layer && tile_id < 16'd3000;
    cls_anim  = !upper_layer && tile_id >= 16'd3000 && tile_id < 16'd4000;
    cls_terr  = !upper_layer && tile_id >= 16'd4000 && tile_id < 16'd4600;
    cls_plain = !upper_layer && tile_id >= 16'd5000;
    base_cx = (tile_id >= 16'd1000 && tile_id < 16'd2000) ? 5'd3 : 5'd0;
    g = 4'(idx50 - 16'd80);
    gg = 4'(idx50 - 16'd63);
    cx = 5'd18;
    cy = 4'd8;
    if (cls_up || cls_plain) begin
      cx = 5'(32'(blk >> 1) * 6 + 32'(px));
      cy = {blk[0], py[2:0]};
    end else if (tile_id < 16'd3150) begin
      cx = 5'(idx50 - 16'd57);
      cy = 4'd4 + {2'b00, frame[1:0]};
    end else if (tile_id < 16'd3750) begin
      cx = grp_cx(gg);
      cy = grp_cy(gg);
    end
    cmd_en = '0;
    for (int i = 0; i < 8; i++) cmds[i] = '0;
    if (cls_up || cls_plain || cls_anim) begin
      cmd_en[0] = 1'b1;
      cmds[0] = '{src_x: {cx, 4'd0}, src_y: {cy, 4'd0}, dst_x: 4'd0, dst_y: 4'd0,
                  whole_tile: 1'b1};
    end
    for (int i = 0; i < 4; i++) begin
      ox = i[0] ? 4'd8 : 4'd0;
      oy = i[1] ? 4'd8 : 4'd0;
      if (cls_coast) begin
        t = (tile_id < 16'd2000) ? {1'b0, bits[i]} : (bits[i] ? 2'd2 : 2'd3);
        cmd_en[i] = 1'b1;
        cmds[i] = '{src_x: {3'd0, f3, 4'd0} + 9'(ox), src_y: {2'b01, t, 4'd0} + 8'(oy),
                    dst_x: ox, dst_y: oy, whole_tile: 1'b0};
        cmd_en[4+i] = (q[i] != PC_NONE);
        cmds[4+i] = '{src_x: {base_cx + 5'(f3), 4'd0} + 9'(ox),
                      src_y: {q[i], 4'd0} + 8'(oy), dst_x: ox, dst_y: oy,
                      whole_tile: 1'b0};
      end else if (cls_terr) begin
        cmd_en[i] = 1'b1;
        cmds[i] = '{src_x: {grp_cx(g) + 5'(pc_col(t_q[i])), 4'd0} + 9'(ox),
                    src_y: {grp_cy(g) + 4'(pc_row(t_q[i])), 4'd0} + 8'(oy),
                    dst_x: ox, dst_y: oy, whole_tile: 1'b0};
      end
    end
  end

endmodule

[hw/rtl/autotile_quarter_source_lookup.sv]
// Top level of the autotile quarter source lookup.
// Depends on atq_pkg and atq_decode.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  tile_id, upper_layer, frame
//   out      source     out_valid/out_stall src_x, src_y, dst_x, dst_y, whole_tile, last
//
// A tile beat is registered, decoded and loaded into a bank of up to eight
// commands, and a tile may produce none; the bank then sends one command per
// cycle while out is not stalled. A new tile is taken in the cycle the bank
// sends its last command. Reset clears the valid flags. A stall on out holds
// the current command.
module autotile_quarter_source_lookup (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] tile_id,
  input  logic        upper_layer,
  input  logic [15:0] frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  src_x,
  output logic [7:0]  src_y,
  output logic [3:0]  dst_x,
  output logic [3:0]  dst_y,
  output logic        whole_tile,
  output logic        last
);
  import atq_pkg::*;

  logic        in_full;
  logic [15:0] r_id, r_frame;
  logic        r_up;
  cmd_t [7:0]  dec_cmds;
  logic [7:0]  dec_en;
  cmd_t [7:0]  bank;
  logic [7:0]  pend, pend_next;
  logic [2:0]  sel;
  logic        bank_load, in_take, send, bank_done;

  atq_decode u_dec (.tile_id(r_id), .upper_layer(r_up), .frame(r_frame),
                    .cmds(dec_cmds), .cmd_en(dec_en));

  // Lowest pending command goes out next.
  always_comb begin
    sel = 3'd0;
    for (int i = 7; i >= 0; i--) if (pend[i]) sel = 3'(i);
  end

  assign out_valid  = |pend;
  assign send       = out_valid && !out_stall;
  assign pend_next  = send ? (pend & ~(8'd1 << sel)) : pend;
  assign bank_done  = (pend_next == 8'd0);
  assign bank_load  = in_full && bank_done;
  assign in_stall   = in_full && !bank_load;
  assign in_take    = in_valid && !in_stall;
  assign last       = ((pend & ~(8'd1 << sel)) == 8'd0);
  assign src_x      = bank[sel].src_x;
  assign src_y      = bank[sel].src_y;
  assign dst_x      = bank[sel].dst_x;
  assign dst_y      = bank[sel].dst_y;
  assign whole_tile = bank[sel].whole_tile;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !bank_load);
    end
    if (in_take) begin
      r_id <= tile_id;
      r_up <= upper_layer;
      r_frame <= frame;
    end
  end

  // Command bank.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= bank_load ? dec_en : pend_next;
    end
    if (bank_load) bank <= dec_cmds;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sel))
    else $error("pending command lost under stall");
  a_last: assert property (@(posedge clk) disable iff (rst)
    send && last |=> !out_valid || $past(bank_load))
    else $error("command sent after last");
  a_nodrop: assert property (@(posedge clk) disable iff (rst)
    in_full && !bank_load |=> in_full)
    else $error("tile dropped");

endmodule

[tb/sv/autotile_quarter_source_lookup_test.sv]
// Testbench for the autotile quarter source lookup.
// Depends on atq_pkg (piece codes, command record) and the top-level block.
// A behavioral decoder predicts every blit command; a monitor checks each beat.
`timescale 1ns / 1ps

module autotile_quarter_source_lookup_test;
  import atq_pkg::*;

  typedef struct packed {
    logic [15:0] tile_id;
    logic        upper_layer;
    logic [15:0] frame;
  } tile_t;

  typedef struct packed {
    cmd_t cmd;
    logic last;
  } blit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] tile_id = '0;
  logic        upper_layer = 1'b0;
  logic [15:0] frame = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  src_x;
  logic [7:0]  src_y;
  logic [3:0]  dst_x;
  logic [3:0]  dst_y;
  logic        whole_tile;
  logic        last;

  tile_t pending_tiles[$];
  blit_t expected_blits[$];
  int    mismatches = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  bit    feed_done = 0;
  int    cycles = 0;

  autotile_quarter_source_lookup uut (.*);

  always #6 clk = ~clk;

  // Sheet cell tables for the twelve 50-id groups.
  function automatic int cell_x(int g);
    int t[12] = '{0, 3, 0, 3, 6, 9, 6, 9, 6, 9, 6, 9};
    return t[g];
  endfunction

  function automatic int cell_y(int g);
    int t[12] = '{8, 8, 12, 12, 0, 0, 4, 4, 8, 8, 12, 12};
    return t[g];
  endfunction

  function automatic void push_blit(int sx, int sy, int dx, int dy, bit whole);
    blit_t b;
    b.cmd.src_x = sx[8:0];
    b.cmd.src_y = sy[7:0];
    b.cmd.dst_x = dx[3:0];
    b.cmd.dst_y = dy[3:0];
    b.cmd.whole_tile = whole;
    b.last = 1'b0;
    expected_blits.insert(expected_blits.size(), b);
  endfunction

  // Plain tiles fold a 6-wide index into 6x8 blocks.
  function automatic void push_plain(int rel);
    int px, py, blk;
    px = rel % 6;
    py = rel / 6;
    blk = py / 8;
    if (blk > 9) blk = 9;
    push_blit(((blk / 2) * 6 + px) << 4, ((blk & 1) * 8 + (py & 7)) << 4, 0, 0, 1);
  endfunction

  function automatic void coast_pieces(int c, ref logic [3:0] q[4]);
    foreach (q[i]) q[i] = PC_NONE;
    if (c < 'h10) begin
      if (c & 1) q[0] = PC_D;
      if (c & 2) q[1] = PC_D;
      if (c & 4) q[3] = PC_D;
      if (c & 8) q[2] = PC_D;
    end else if (c < 'h14) begin
      q[0] = PC_B; q[2] = PC_B;
      if (c & 1) q[1] = PC_D;
      if (c & 2) q[3] = PC_D;
    end else if (c < 'h18) begin
      q[0] = PC_C; q[1] = PC_C;
      if (c & 1) q[3] = PC_D;
      if (c & 2) q[2] = PC_D;
    end else if (c < 'h1C) begin
      q[1] = PC_B; q[3] = PC_B;
      if (c & 1) q[2] = PC_D;
      if (c & 2) q[0] = PC_D;
    end else if (c < 'h20) begin
      q[2] = PC_C; q[3] = PC_C;
      if (c & 1) q[0] = PC_D;
      if (c & 2) q[1] = PC_D;
    end else if (c == 'h20) begin
      foreach (q[i]) q[i] = PC_B;
    end else if (c == 'h21) begin
      foreach (q[i]) q[i] = PC_C;
    end else if (c <= 'h23) begin
      q[0] = PC_A; q[2] = PC_B; q[1] = PC_C;
      if (c & 1) q[3] = PC_D;
    end else if (c <= 'h25) begin
      q[1] = PC_A; q[3] = PC_B; q[0] = PC_C;
      if (c & 1) q[2] = PC_D;
    end else if (c <= 'h27) begin
      q[3] = PC_A; q[1] = PC_B; q[2] = PC_C;
      if (c & 1) q[0] = PC_D;
    end else if (c <= 'h29) begin
      q[2] = PC_A; q[0] = PC_B; q[3] = PC_C;
      if (c & 1) q[1] = PC_D;
    end else if (c == 'h2A) begin
      q[0] = PC_A; q[1] = PC_A; q[2] = PC_B; q[3] = PC_B;
    end else if (c == 'h2B) begin
      q[0] = PC_A; q[2] = PC_A; q[1] = PC_C; q[3] = PC_C;
    end else if (c == 'h2C) begin
      q[2] = PC_A; q[3] = PC_A; q[0] = PC_B; q[1] = PC_B;
    end else if (c == 'h2D) begin
      q[1] = PC_A; q[3] = PC_A; q[0] = PC_C; q[2] = PC_C;
    end else begin
      foreach (q[i]) q[i] = PC_A;
    end
  endfunction

  function automatic void terrain_pieces(int c, ref logic [3:0] q[4]);
    foreach (q[i]) q[i] = PT_D5;
    if (c < 'h10) begin
      if (c & 1) q[0] = PT_C;
      if (c & 2) q[1] = PT_C;
      if (c & 4) q[3] = PT_C;
      if (c & 8) q[2] = PT_C;
    end else if (c < 'h14) begin
      q[0] = PT_D4; q[2] = PT_D4;
      if (c & 1) q[1] = PT_C;
      if (c & 2) q[3] = PT_C;
    end else if (c < 'h18) begin
      q[0] = PT_D8; q[1] = PT_D8;
      if (c & 1) q[3] = PT_C;
      if (c & 2) q[2] = PT_C;
    end else if (c < 'h1C) begin
      q[1] = PT_D6; q[3] = PT_D6;
      if (c & 1) q[2] = PT_C;
      if (c & 2) q[0] = PT_C;
    end else if (c < 'h20) begin
      q[2] = PT_D2; q[3] = PT_D2;
      if (c & 1) q[0] = PT_C;
      if (c & 2) q[1] = PT_C;
    end else if (c == 'h20) begin
      q[0] = PT_D4; q[2] = PT_D4; q[1] = PT_D6; q[3] = PT_D6;
    end else if (c == 'h21) begin
      q[0] = PT_D8; q[1] = PT_D8; q[2] = PT_D2; q[3] = PT_D2;
    end else if (c <= 'h23) begin
      foreach (q[i]) q[i] = PT_D7;
      if (c & 1) q[3] = PT_C;
    end else if (c <= 'h25) begin
      foreach (q[i]) q[i] = PT_D9;
      if (c & 1) q[2] = PT_C;
    end else if (c <= 'h27) begin
      foreach (q[i]) q[i] = PT_D3;
      if (c & 1) q[0] = PT_C;
    end else if (c <= 'h29) begin
      foreach (q[i]) q[i] = PT_D1;
      if (c & 1) q[1] = PT_C;
    end else if (c == 'h2A) begin
      q[0] = PT_D7; q[2] = PT_D7; q[1] = PT_D9; q[3] = PT_D9;
    end else if (c == 'h2B) begin
      q[0] = PT_D7; q[1] = PT_D7; q[2] = PT_D1; q[3] = PT_D1;
    end else if (c == 'h2C) begin
      q[0] = PT_D1; q[2] = PT_D1; q[1] = PT_D3; q[3] = PT_D3;
    end else if (c == 'h2D) begin
      q[0] = PT_D9; q[1] = PT_D9; q[2] = PT_D3; q[3] = PT_D3;
    end else begin
      q[0] = PT_D7; q[1] = PT_D9; q[2] = PT_D1; q[3] = PT_D3;
    end
  endfunction

  // Appends the blit commands that one tile decodes into.
  function automatic void predict_blits(tile_t t);
    int id, f3, bits, base_cx, g, start, setb, row;
    logic [3:0] q[4];
    int ox[4] = '{0, 8, 0, 8};
    int oy[4] = '{0, 0, 8, 8};
    id = t.tile_id;
    start = expected_blits.size();
    if (t.upper_layer) begin
      if (id >= 10000 && id < 10144) push_plain(id - 10000 + 336);
    end else if (id < 3000) begin
      bits = (id % 800) / 50;
      base_cx = (id >= 1000 && id < 2000) ? 3 : 0;
      f3 = t.frame % 3;
      for (int i = 0; i < 4; i++) begin
        setb = (bits >> i) & 1;
        row = (id < 2000) ? setb : (setb ? 2 : 3);
        push_blit((f3 << 4) + ox[i], ((row + 4) << 4) + oy[i], ox[i], oy[i], 0);
      end
      coast_pieces(id % 50, q);
      for (int i = 0; i < 4; i++) begin
        if (q[i] != PC_NONE)
          push_blit(((base_cx + f3) << 4) + ox[i], (int'(q[i]) << 4) + oy[i],
                    ox[i], oy[i], 0);
      end
    end else if (id < 3150) begin
      push_blit((3 + (id - 3000) / 50) << 4, (4 + (t.frame & 3)) << 4, 0, 0, 1);
    end else if (id < 3750) begin
      g = (id - 3150) / 50;
      push_blit(cell_x(g) << 4, cell_y(g) << 4, 0, 0, 1);
    end else if (id < 4000) begin
      push_blit(18 << 4, 8 << 4, 0, 0, 1);
    end else if (id < 4600) begin
      g = (id - 4000) / 50;
      terrain_pieces(id % 50, q);
      for (int i = 0; i < 4; i++)
        push_blit(((cell_x(g) + q[i] % 3) << 4) + ox[i],
                  ((cell_y(g) + q[i] / 3) << 4) + oy[i], ox[i], oy[i], 0);
    end else if (id >= 5000) begin
      push_plain(id - 5000 + 192);
    end
    if (expected_blits.size() > start)
      expected_blits[expected_blits.size() - 1].last = 1'b1;
  endfunction

  function automatic void queue_tile(int id, bit up, int fr);
    tile_t t;
    t.tile_id = id[15:0];
    t.upper_layer = up;
    t.frame = fr[15:0];
    pending_tiles.insert(pending_tiles.size(), t);
  endfunction

  // Random tile drawn mostly from the decoding ranges that produce commands.
  function automatic void queue_random_tile();
    int sel, id;
    bit up;
    sel = $urandom_range(0, 9);
    up = 1'b0;
    case (sel)
      0, 1, 2: id = $urandom_range(0, 2999);
      3: id = $urandom_range(3000, 3999);
      4, 5: id = $urandom_range(4000, 4599);
      6: id = $urandom_range(4600, 65535);
      7: begin id = $urandom_range(10000, 10143); up = 1'b1; end
      8: begin id = $urandom_range(0, 65535); up = 1'b1; end
      default: begin id = $urandom_range(0, 65535); up = $urandom_range(0, 1); end
    endcase
    queue_tile(id, up, $urandom_range(0, 65535));
  endfunction

  // Driver: presents pending tiles and predicts each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_blits(pending_tiles.pop_front());
      end
      if ((!in_valid || !in_stall) && pending_tiles.size() > 0
          && (in_valid && !in_stall ? pending_tiles.size() > 0 : 1)) begin
        if ($urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          tile_id <= pending_tiles[0].tile_id;
          upper_layer <= pending_tiles[0].upper_layer;
          frame <= pending_tiles[0].frame;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each command beat against the oldest expectation.
  always @(posedge clk) begin
    blit_t want;
    if (!rst) begin
      cycles <= cycles + 1;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_blits.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("ERROR: unexpected command src=(%0d,%0d) dst=(%0d,%0d)",
                     src_x, src_y, dst_x, dst_y);
        end else begin
          want = expected_blits.pop_front();
          if (want.cmd.src_x !== src_x || want.cmd.src_y !== src_y ||
              want.cmd.dst_x !== dst_x || want.cmd.dst_y !== dst_y ||
              want.cmd.whole_tile !== whole_tile || want.last !== last) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display({"ERROR: expected src=(%0d,%0d) dst=(%0d,%0d) whole=%0b last=%0b,",
                        " got src=(%0d,%0d) dst=(%0d,%0d) whole=%0b last=%0b"},
                       want.cmd.src_x, want.cmd.src_y, want.cmd.dst_x, want.cmd.dst_y,
                       want.cmd.whole_tile, want.last, src_x, src_y, dst_x, dst_y,
                       whole_tile, last);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int pc[4] = '{0, 66, 0, 35};
    int sc[4] = '{0, 0, 66, 35};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed tiles: field extremes, every decoding range and the skipped ones.
    queue_tile(0, 0, 0);
    queue_tile(2999, 0, 65535);
    queue_tile(1049, 0, 1);
    queue_tile(2046, 0, 2);
    queue_tile(1445, 0, 5);
    queue_tile(3000, 0, 3);
    queue_tile(3149, 0, 65535);
    queue_tile(3150, 0, 0);
    queue_tile(3749, 0, 0);
    queue_tile(3750, 0, 0);
    queue_tile(3999, 0, 0);
    queue_tile(4000, 0, 0);
    queue_tile(4049, 0, 0);
    queue_tile(4599, 0, 0);
    queue_tile(4600, 0, 0);
    queue_tile(4999, 0, 0);
    queue_tile(5000, 0, 0);
    queue_tile(65535, 0, 65535);
    queue_tile(10000, 1, 0);
    queue_tile(10143, 1, 0);
    queue_tile(10144, 1, 0);
    queue_tile(9999, 1, 0);
    queue_tile(0, 1, 0);
    queue_tile(65535, 1, 65535);

    for (int p = 0; p < 4; p++) begin
      idle_pct = pc[p];
      stall_pct = sc[p];
      for (int n = 0; n < 102; n++) queue_random_tile();
      while (pending_tiles.size() != 0) @(posedge clk);
    end
    stall_pct = 0;
    while (pending_tiles.size() != 0 || in_valid || expected_blits.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_blits.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
